[rtl/dlc_pkg.sv]
// Shared constants for the direct-form linear convolution block.
// No dependencies; dlc_if.sv and direct_linear_convolution.sv import this package.
`default_nettype none

package dlc_pkg;

  // Field widths that do not move with the module parameters.
  localparam int RESULT_BITS    = 38;
  localparam int TAP_INDEX_BITS = 6;
  localparam int TAP_COUNT_BITS = 7;

  // Codes of the kind field of an input transaction.
  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

endpackage

`default_nettype wire

[rtl/dlc_if.sv]
// Valid/ready channel interfaces for the convolution block's input and output.
// Depends on dlc_pkg for the fixed field widths.
`default_nettype none

interface dlc_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import dlc_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [TAP_INDEX_BITS-1:0]        tap_index;
  logic signed [SAMPLE_BITS-1:0]    value;
  logic                             last_sample;

  modport source (output valid, kind, tap_index, value, last_sample, input ready);
  modport sink   (input valid, kind, tap_index, value, last_sample, output ready);
endinterface

interface dlc_out_if;
  import dlc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] result;
  logic                          last;

  modport source (output valid, result, last, input ready);
  modport sink   (input valid, result, last, output ready);
endinterface

`default_nettype wire

[rtl/dlc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dlc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/direct_linear_convolution.sv]
// Direct-form full linear convolution, y[n] = sum h[m] * x[n-m], top level.
// Depends on dlc_pkg, the dlc_in_if / dlc_out_if interfaces and dlc_ram.
`default_nettype none

// A user of this block writes the taps first: an input transaction of kind
// KIND_COEF stores its value at tap_index (indexes at or above MAX_TAPS are
// dropped) and produces nothing. tap_count, written through tap_count_we and
// tap_count_wdata while the block is idle, selects how many taps are summed;
// zero acts as one and values above MAX_TAPS act as MAX_TAPS. Each transaction
// of kind KIND_SAMPLE shifts its value into the signal history and returns one
// exact Q8.30 sum over tap_count taps. A sample with last_sample set returns
// tap_count-1 further tail sums, flags the final one with last, and empties
// the history for the next signal. For each output sum, one shared
// multiply-accumulate issues one tap read per cycle; then the memory data is
// brought into the product register, the product is added to the
// accumulator, the walk sees the pipeline empty, and the output register is
// loaded. A sample is first accepted in the idle state. A finished sum waits
// in the output register while the next transaction is taken and worked on;
// the block only stalls when a new sum is ready and the previous one is still
// unclaimed. The history lives in a circular memory with a fill count, so no
// clearing pass is needed after reset or after a last sample.
module direct_linear_convolution #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  tap_count_we,
  input  wire logic [dlc_pkg::TAP_COUNT_BITS-1:0]    tap_count_wdata,
  dlc_in_if.sink                                     item,
  dlc_out_if.source                                  result_item
);
  import dlc_pkg::*;

  // Address width of both memories, width of tap counters (they hold MAX_TAPS
  // itself), and the history depth as a power of two so the pointer wraps.
  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int HDEPTH = 1 << AW;
  localparam int PW     = 2 * SAMPLE_BITS;
  localparam int EW     = (PW > RESULT_BITS) ? PW : RESULT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                 state;
  logic [TAP_COUNT_BITS-1:0]  tap_count;

  // History bookkeeping: wp points at the newest sample, fill counts how many
  // entries behind it hold real samples since the last clear.
  logic [AW-1:0]              wp;
  logic [CW-1:0]              fill;

  // Per-output walk.
  logic [CW-1:0]              taps;
  logic [CW-1:0]              m;
  logic [CW-1:0]              tail;
  logic                       last_pend;
  logic                       p1;
  logic                       p1_ok;
  logic                       p2;
  logic signed [PW-1:0]       prod;
  logic [RESULT_BITS-1:0]     acc;

  // Output register.
  logic                       out_valid;
  logic [RESULT_BITS-1:0]     out_result;
  logic                       out_last;

  logic [TAP_COUNT_BITS-1:0]  tc_clamped;
  logic [CW-1:0]              taps_eff;
  logic                       accept;
  logic                       accept_sample;
  logic                       accept_coef;
  logic                       emit_fire;
  logic                       issue;
  logic                       hist_we;
  logic [AW-1:0]              hist_waddr;
  logic [SAMPLE_BITS-1:0]     hist_wdata;
  logic [AW-1:0]              hist_raddr;
  logic [SAMPLE_BITS-1:0]     hist_rdata;
  logic [SAMPLE_BITS-1:0]     coef_rdata;
  logic [SAMPLE_BITS-1:0]     hist_masked;
  logic signed [EW-1:0]       prod_ext;
  logic [CW-1:0]              fill_inc;

  // Tap count saturates to the range one to MAX_TAPS.
  always_comb begin
    if (tap_count == '0) begin
      tc_clamped = TAP_COUNT_BITS'(1);
    end else if (tap_count > TAP_COUNT_BITS'(MAX_TAPS)) begin
      tc_clamped = TAP_COUNT_BITS'(MAX_TAPS);
    end else begin
      tc_clamped = tap_count;
    end
  end
  assign taps_eff = CW'(tc_clamped);

  assign item.ready    = (state == S_IDLE);
  assign accept        = item.valid && (state == S_IDLE);
  assign accept_sample = accept && (item.kind == KIND_SAMPLE);
  assign accept_coef   = accept && (item.kind == KIND_COEF) &&
                         (TAP_COUNT_BITS'(item.tap_index) < TAP_COUNT_BITS'(MAX_TAPS));
  assign emit_fire     = (state == S_EMIT) && (!out_valid || result_item.ready);
  assign issue         = (state == S_MAC) && (m < taps);
  assign fill_inc      = (fill == CW'(MAX_TAPS)) ? fill : fill + CW'(1);

  // A new sample enters on accept; a zero enters before each tail output.
  // Writes and reads of the history never fall in the same cycle, so the
  // memory needs no forwarding.
  assign hist_we    = accept_sample || (emit_fire && (tail != '0));
  assign hist_waddr = wp + AW'(1);
  assign hist_wdata = (state == S_IDLE) ? item.value : '0;
  assign hist_raddr = wp - m[AW-1:0];

  dlc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (accept_coef),
    .waddr (item.tap_index[AW-1:0]),
    .wdata (item.value),
    .raddr (m[AW-1:0]),
    .rdata (coef_rdata)
  );

  dlc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Entries older than the fill count read as zero: that is the cleared history.
  assign hist_masked = p1_ok ? hist_rdata : '0;
  assign prod_ext    = EW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= TAP_COUNT_BITS'(1);
      wp        <= '0;
      fill      <= '0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tap_count_we) begin
        tap_count <= tap_count_wdata;
      end

      // Read pipeline: address issued, memory data back, product registered.
      p1    <= issue;
      p1_ok <= (m < fill);
      p2    <= p1;
      prod  <= $signed(coef_rdata) * $signed(hist_masked);
      if (issue) begin
        m <= m + CW'(1);
      end
      if (p2) begin
        acc <= acc + prod_ext[RESULT_BITS-1:0];
      end

      if (emit_fire) begin
        out_valid  <= 1'b1;
        out_result <= acc;
        out_last   <= last_pend && (tail == '0);
      end else if (result_item.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept_sample) begin
            wp        <= wp + AW'(1);
            fill      <= fill_inc;
            taps      <= taps_eff;
            // Only a last sample drains the history through tail outputs.
            tail      <= item.last_sample ? taps_eff - CW'(1) : '0;
            last_pend <= item.last_sample;
            m         <= '0;
            acc       <= '0;
            state     <= S_MAC;
          end
        end
        S_MAC: begin
          if (!issue && !p1 && !p2) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (tail != '0) begin
              wp    <= wp + AW'(1);
              fill  <= fill_inc;
              tail  <= tail - CW'(1);
              m     <= '0;
              acc   <= '0;
              state <= S_MAC;
            end else begin
              if (last_pend) begin
                fill <= '0;
              end
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_item.valid  = out_valid;
  assign result_item.result = out_result;
  assign result_item.last   = out_last;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the direct-form linear convolution block.
// Depends on dlc_pkg, the dlc_in_if / dlc_out_if interfaces and the RTL top level.
// Checks every output sum and last flag against a built-in convolution predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dlc_pkg::*;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  // Longest receiver hold-off, in cycles, used to back the block up.
  localparam int LONG_HOLD   = 500;
  // Quiet cycles after the last result before a register write or the end:
  // a coefficient write produces nothing.
  localparam int SETTLE      = 2 * (MAX_TAPS + 5) + 20;
  localparam int RANDOM_ITEMS = 100;

  // One input transaction as the generator queues it.
  typedef struct {
    logic                          kind;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_sample;
  } conv_item_t;

  // One predicted output transaction.
  typedef struct {
    logic signed [RESULT_BITS-1:0] result;
    logic                          last;
  } conv_out_t;

  logic clk;
  logic rst;
  logic tap_count_we;
  logic [TAP_COUNT_BITS-1:0] tap_count_wdata;

  dlc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
  dlc_out_if res_ch ();

  direct_linear_convolution #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .tap_count_we    (tap_count_we),
    .tap_count_wdata (tap_count_wdata),
    .item            (item_ch),
    .result_item     (res_ch)
  );

  // Clock and the single reset at the start of the run.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Transactions waiting to be offered, and sums waiting to be seen.
  conv_item_t pending_items[$];
  conv_out_t  expected_outputs[$];

  // Generator-side bookkeeping: which taps hold a written value and how many
  // taps the block will sum, so no sample ever reads an unwritten tap.
  bit coef_written[MAX_TAPS];
  int gen_taps;
  int queued_items;

  // Predictor state: its own copy of the taps, the history and the register.
  logic signed [SAMPLE_BITS-1:0] coef_copy[MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_copy[MAX_TAPS];
  logic [TAP_COUNT_BITS-1:0]     tap_count_copy;

  // Flags the stimulus sets per phase to turn idling off on either side.
  bit sender_steady;
  bit receiver_steady;
  // Long hold-off requests, served by the receiver process.
  int hold_requests;
  int hold_served;

  int mismatch_count;
  int results_checked;
  int samples_sent;
  int coefs_sent;
  int settings_written;

  // Gap length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample or tap value with the extremes favored.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7fff;
    if (r < 25) return '0;
    return SAMPLE_BITS'($urandom);
  endfunction

  // Number of taps the block sums for a given register value.
  function automatic int taps_for(input logic [TAP_COUNT_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_TAPS) return MAX_TAPS;
    return int'(v);
  endfunction

  // Exact sum of products over the first taps entries of the history window.
  function automatic logic signed [RESULT_BITS-1:0] window_sum(input int taps);
    longint acc;
    acc = 0;
    for (int m = 0; m < taps; m++) begin
      acc += longint'(coef_copy[m]) * longint'(hist_copy[m]);
    end
    return acc[RESULT_BITS-1:0];
  endfunction

  // Shift one value into the predictor's history, newest at position zero.
  function automatic void shift_history(input logic signed [SAMPLE_BITS-1:0] v);
    for (int m = MAX_TAPS - 1; m > 0; m--) begin
      hist_copy[m] = hist_copy[m-1];
    end
    hist_copy[0] = v;
  endfunction

  // Work out every output sum that one accepted transaction causes.
  function automatic void predict_outputs(input conv_item_t it);
    int taps;
    conv_out_t o;
    if (it.kind == KIND_COEF) begin
      // A tap write produces nothing; its last_sample bit is ignored.
      coef_copy[it.tap_index] = it.value;
      return;
    end
    taps = taps_for(tap_count_copy);
    shift_history(it.value);
    o.result = window_sum(taps);
    o.last   = it.last_sample && (taps == 1);
    expected_outputs.push_back(o);
    if (it.last_sample) begin
      // Tail of the convolution: zeros shift in until the signal has drained.
      for (int k = 1; k < taps; k++) begin
        shift_history('0);
        o.result = window_sum(taps);
        o.last   = (k == taps - 1);
        expected_outputs.push_back(o);
      end
      for (int m = 0; m < MAX_TAPS; m++) hist_copy[m] = '0;
    end
  endfunction

  // Predictor: follows register writes and accepted input transactions at the
  // same edges at which the block takes them.
  always @(posedge clk) begin
    if (rst) begin
      tap_count_copy <= TAP_COUNT_BITS'(1);
      for (int m = 0; m < MAX_TAPS; m++) hist_copy[m] = '0;
    end else begin
      if (tap_count_we) tap_count_copy <= tap_count_wdata;
      if (item_ch.valid && item_ch.ready) begin
        predict_outputs('{item_ch.kind, item_ch.tap_index, item_ch.value,
                          item_ch.last_sample});
      end
    end
  end

  // Driver: offers the oldest pending transaction, with random gaps after
  // each accepted one unless sender_steady. valid gets at most one assignment
  // per edge, so a back-to-back transaction keeps valid high without a glitch.
  int tx_gap;
  bit offering;
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      offering = item_ch.valid;
      if (item_ch.valid && item_ch.ready) begin
        void'(pending_items.pop_front());
        offering = 1'b0;
        if (!sender_steady) tx_gap = pick_gap();
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_ch.valid       <= 1'b1;
          item_ch.kind        <= pending_items[0].kind;
          item_ch.tap_index   <= pending_items[0].tap_index;
          item_ch.value       <= pending_items[0].value;
          item_ch.last_sample <= pending_items[0].last_sample;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls after each result unless receiver_steady, plus the
  // long hold-offs that the stimulus asks for, counted here cycle by cycle.
  int rx_gap;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (res_ch.valid && res_ch.ready && !receiver_steady) rx_gap = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: every accepted result is compared with the oldest expectation.
  conv_out_t want;
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result %0d last %0b", $realtime,
                 res_ch.result, res_ch.last);
        mismatch_count++;
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (res_ch.result !== want.result) begin
          $display("%0t: result mismatch, expected %0d, actual %0d", $realtime,
                   want.result, res_ch.result);
          mismatch_count++;
        end
        if (res_ch.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b", $realtime,
                   want.last, res_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // Queue a tap write.
  task automatic add_coef(input int idx, input logic signed [SAMPLE_BITS-1:0] v,
                          input bit lastf);
    pending_items.push_back('{KIND_COEF, TAP_INDEX_BITS'(idx), v, lastf});
    coef_written[idx] = 1'b1;
    coefs_sent++;
    queued_items++;
  endtask

  // Queue a signal sample, writing any tap in use that still lacks a value.
  task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] v, input bit lastf);
    for (int m = 0; m < gen_taps; m++) begin
      if (!coef_written[m]) add_coef(m, pick_value(), 1'b0);
    end
    pending_items.push_back('{KIND_SAMPLE, '0, v, lastf});
    samples_sent++;
    queued_items++;
  endtask

  // The sender pauses here until everything queued is accepted, every
  // expected sum has arrived and the block has had time to finish any tap
  // write still in progress. The extra edge lets the predictor record the
  // sums of the last accepted transaction before the queue is checked.
  task automatic wait_idle();
    while (pending_items.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write, only ever issued while the block is idle.
  task automatic write_tap_count(input logic [TAP_COUNT_BITS-1:0] v);
    @(posedge clk);
    tap_count_we    <= 1'b1;
    tap_count_wdata <= v;
    @(posedge clk);
    tap_count_we    <= 1'b0;
    gen_taps = taps_for(v);
    settings_written++;
  endtask

  // Stimulus: a directed part, a pressure phase, then random phases.
  int directed_items;
  int r;
  int n;
  logic [TAP_COUNT_BITS-1:0] setting;
  initial begin
    rst             = 1'b1;
    tap_count_we    = 1'b0;
    tap_count_wdata = '0;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_COEF;
    item_ch.tap_index   = '0;
    item_ch.value       = '0;
    item_ch.last_sample = 1'b0;
    res_ch.ready    = 1'b0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    hold_requests   = 0;
    hold_served     = 0;
    mismatch_count  = 0;
    results_checked = 0;
    samples_sent    = 0;
    coefs_sent      = 0;
    settings_written = 0;
    queued_items    = 0;
    gen_taps        = 1;
    for (int m = 0; m < MAX_TAPS; m++) coef_written[m] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset value of tap_count is one: most negative times most negative is
    // the largest positive product, and a single-tap last sample flags last
    // on its own output.
    add_coef(0, 16'sh8000, 1'b0);
    add_sample(16'sh8000, 1'b0);
    add_sample(16'sh7fff, 1'b0);
    add_sample(16'sh0000, 1'b1);
    // A tap write ignores last_sample.
    add_coef(0, 16'sh7fff, 1'b1);
    add_sample(16'sh8000, 1'b1);
    wait_idle();

    // Zero in the register acts as a single tap.
    write_tap_count(0);
    add_sample(16'sh0001, 1'b1);
    wait_idle();

    // Four taps with alternating extremes, then a drain on a last sample.
    write_tap_count(4);
    add_coef(1, 16'sh7fff, 1'b0);
    add_coef(2, 16'sh8000, 1'b0);
    add_coef(3, 16'shffff, 1'b0);
    add_sample(16'sh7fff, 1'b0);
    add_sample(16'sh8000, 1'b0);
    add_sample(16'sh7fff, 1'b0);
    add_sample(16'sh8000, 1'b1);
    add_sample(16'shffff, 1'b1);
    wait_idle();

    // The tap count changes in the middle of a signal; the history survives.
    write_tap_count(2);
    add_sample(16'sd100, 1'b0);
    wait_idle();
    write_tap_count(3);
    add_sample(16'sd200, 1'b0);
    add_sample(-16'sd300, 1'b1);
    wait_idle();
    directed_items = queued_items;

    // Pressure: the receiver holds off for a long stretch while the sender
    // keeps offering samples back to back, so the block backs up and stalls.
    write_tap_count(2);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    hold_requests++;
    repeat (30) add_sample(pick_value(), 1'b0);
    add_sample(pick_value(), 1'b1);
    wait_idle();

    // Random phases. The first uses the all-ones register value, which
    // saturates to the full tap count and forces every tap to be written.
    setting = '1;
    while (queued_items < directed_items + RANDOM_ITEMS) begin
      write_tap_count(setting);
      sender_steady   = ($urandom_range(0, 4) == 0);
      receiver_steady = ($urandom_range(0, 4) == 0);
      n = $urandom_range(4, 16);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 18) add_coef($urandom_range(0, MAX_TAPS - 1), pick_value(),
                             1'($urandom_range(0, 1)));
        else add_sample(pick_value(), ($urandom_range(0, 5) == 0));
      end
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        case ($urandom_range(0, 3))
          0: setting = TAP_COUNT_BITS'(0);
          1: setting = TAP_COUNT_BITS'(MAX_TAPS);
          2: setting = TAP_COUNT_BITS'(MAX_TAPS + 1);
          default: setting = '1;
        endcase
      end else if (r < 30) begin
        setting = TAP_COUNT_BITS'($urandom_range(9, 24));
      end else begin
        setting = TAP_COUNT_BITS'($urandom_range(1, 8));
      end
    end

    // Close the open signal so its tail is checked too.
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    add_sample(pick_value(), 1'b1);
    wait_idle();

    $display("Covered %0d samples and %0d tap writes over %0d tap_count settings,",
             samples_sent, coefs_sent, settings_written);
    $display("with %0d output sums checked, including a long receiver hold-off.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("Timeout with %0d sums still expected", expected_outputs.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
